@@ design/cfg_pkg.sv @@
// Shared constants, register map and the quarter-wave sine ROM of the curve generator.
package cfg_pkg;

   localparam int SINE_DEPTH  = 1024;
   localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
   localparam int SINE_ADDR_W = SINE_IDX_W + 1;
   localparam int SINE_W      = 17;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint ONE_Q30     = 64'sd1073741824;

   localparam logic [2:0] REG_MODE        = 3'd0;
   localparam logic [2:0] REG_COEFF_COUNT = 3'd1;
   localparam logic [2:0] REG_COEFFS_LOW  = 3'd2;
   localparam logic [2:0] REG_COEFFS_HIGH = 3'd3;
   localparam logic [2:0] REG_AMPLITUDE   = 3'd4;
   localparam logic [2:0] REG_FREQUENCY   = 3'd5;
   localparam logic [2:0] REG_PHASE       = 3'd6;
   localparam logic [2:0] REG_BIAS        = 3'd7;

   localparam logic [1:0] MODE_CONST = 2'd0;
   localparam logic [1:0] MODE_POLY  = 2'd1;
   localparam logic [1:0] MODE_SINE  = 2'd2;
   localparam logic [1:0] MODE_ZERO  = 2'd3;

   localparam int TAYLOR_TERMS = 12;

   typedef longint taylor_div_type [1:TAYLOR_TERMS];
   localparam taylor_div_type TAYLOR_DIV = '{
      6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

   typedef logic [SINE_W-1:0] sine_rom_type [0:SINE_DEPTH];

   // Elaboration-time build of sin(pi/2 * k / depth) in Q1.16.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint a;
      longint term;
      longint sum;
      longint t;
      longint r;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         a    = (longint'(k) * HALF_PI_Q30) / SINE_DEPTH;
         term = a;
         sum  = a;
         for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            t    = (term * a) / ONE_Q30;
            t    = (t * a) / ONE_Q30;
            t    = t / TAYLOR_DIV[n];
            term = -t;
            sum  = sum + term;
         end
         if (sum < 0) sum = 0;
         r = (sum + 8192) >>> 14;
         if (r > 65536) r = 65536;
         rom[k] = r[SINE_W-1:0];
      end
      rom[SINE_DEPTH] = 17'd65536;
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

@@ design/curve_function_generator_core.sv @@
// Curve function generator top level: constant, Horner polynomial, table sinusoid and zero output.
// An accepted req word reaches its rsp word through seven register stages.
// Throughput: one word per cycle; all stages advance together and hold in place while
// the rsp word waits, so req_tready follows rsp_tready combinationally.
// Stage depth is set by one 32x32 multiply or one wide add and saturate per stage.
// Reset (sync, active high) clears valid bits and config registers; frequency goes to 1.0.
module curve_function_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] x
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] y
   output logic        rsp_tuser,    // [0] saturated
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------- configuration registers ----------------
   logic [1:0]  mode_ff;
   logic [2:0]  count_ff;
   logic [63:0] clo_ff;
   logic [63:0] chi_ff;
   logic [31:0] amp_ff;
   logic [31:0] freq_ff;
   logic [31:0] phase_ff;
   logic [31:0] bias_ff;

   logic csr_wr;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         count_ff <= '0;
         clo_ff   <= '0;
         chi_ff   <= '0;
         amp_ff   <= '0;
         freq_ff  <= 32'd65536;
         phase_ff <= '0;
         bias_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[5:3])
            cfg_pkg::REG_MODE:        mode_ff  <= csr_pwdata[1:0];
            cfg_pkg::REG_COEFF_COUNT: count_ff <= csr_pwdata[2:0];
            cfg_pkg::REG_COEFFS_LOW:  clo_ff   <= csr_pwdata;
            cfg_pkg::REG_COEFFS_HIGH: chi_ff   <= csr_pwdata;
            cfg_pkg::REG_AMPLITUDE:   amp_ff   <= csr_pwdata[31:0];
            cfg_pkg::REG_FREQUENCY:   freq_ff  <= csr_pwdata[31:0];
            cfg_pkg::REG_PHASE:       phase_ff <= csr_pwdata[31:0];
            cfg_pkg::REG_BIAS:        bias_ff  <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[5:3])
         cfg_pkg::REG_MODE:        csr_prdata = {62'd0, mode_ff};
         cfg_pkg::REG_COEFF_COUNT: csr_prdata = {61'd0, count_ff};
         cfg_pkg::REG_COEFFS_LOW:  csr_prdata = clo_ff;
         cfg_pkg::REG_COEFFS_HIGH: csr_prdata = chi_ff;
         cfg_pkg::REG_AMPLITUDE:   csr_prdata = {32'd0, amp_ff};
         cfg_pkg::REG_FREQUENCY:   csr_prdata = {32'd0, freq_ff};
         cfg_pkg::REG_PHASE:       csr_prdata = {32'd0, phase_ff};
         cfg_pkg::REG_BIAS:        csr_prdata = {32'd0, bias_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   logic [31:0] c0, c1, c2, c3;
   assign c0 = clo_ff[31:0];
   assign c1 = clo_ff[63:32];
   assign c2 = chi_ff[31:0];
   assign c3 = chi_ff[63:32];

   // Saturate a 49-bit signed value to 32 bits; returns {clip, value}.
   function automatic logic [32:0] sat32(input logic signed [48:0] v);
      if (v > 49'sd2147483647)       return {1'b1, 32'h7FFF_FFFF};
      else if (v < -49'sd2147483648) return {1'b1, 32'h8000_0000};
      else                           return {1'b0, v[31:0]};
   endfunction

   // One Horner step from a registered product: floor(p / 2^16) + c, saturated.
   // An unused coefficient slot leaves the accumulator at zero.
   function automatic logic [32:0] horner_step(input logic [63:0] p, input logic [31:0] c,
                                               input logic active);
      logic signed [48:0] sum;
      sum = $signed({p[63], p[63:16]}) + $signed({{17{c[31]}}, c});
      if (active) return sat32(sum);
      else        return 33'd0;
   endfunction

   // ---------------- pipeline ----------------
   // Advance every stage together when the output word is empty or being taken.
   logic ce;
   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce & !reset;

   logic [7:1] v_ff;

   always_ff @(posedge clock) begin
      if (reset)   v_ff <= '0;
      else if (ce) v_ff <= {v_ff[6:1], req_tvalid};
   end
   assign rsp_tvalid = v_ff[7];

   // Stage 1: capture x, seed the accumulator with the top coefficient, form frequency * x.
   logic [31:0] x1_ff, acc3_ff, fx1_ff;
   logic [31:0] acc3_in, fx1_in;
   logic signed [63:0] fx_full;
   always_comb begin
      fx_full = $signed(freq_ff) * $signed(req_tdata);
      fx1_in  = fx_full[31:0];
      acc3_in = (count_ff > 3'd3) ? c3 : 32'd0;
   end

   // Stage 2: multiply for step two; phase is added modulo one turn.
   logic [31:0] x2_ff, angle2_ff;
   logic [63:0] p2_ff;
   logic [63:0] p2_in;
   logic [31:0] angle2_in;
   assign p2_in     = $signed(acc3_ff) * $signed(x1_ff);
   assign angle2_in = fx1_ff + phase_ff;

   // ROM address: odd quadrants read the mirrored entry.
   logic [cfg_pkg::SINE_IDX_W-1:0]  sine_idx;
   logic [cfg_pkg::SINE_ADDR_W-1:0] sine_addr;
   always_comb begin
      sine_idx  = angle2_ff[29 -: cfg_pkg::SINE_IDX_W];
      sine_addr = angle2_ff[30]
                ? cfg_pkg::SINE_ADDR_W'(cfg_pkg::SINE_DEPTH) - {1'b0, sine_idx}
                : {1'b0, sine_idx};
   end

   // Stage 3: add for step two, registered ROM read.
   logic [31:0] x3_ff, acc2_ff;
   logic        clip3_ff, neg3_ff;
   logic [cfg_pkg::SINE_W-1:0] rom3_ff;
   logic [32:0] step2_in;
   assign step2_in = horner_step(p2_ff, c2, count_ff > 3'd2);

   // Stage 4: multiply for step one, amplitude times signed sine.
   logic [31:0] x4_ff;
   logic        clip4_ff;
   logic [63:0] p1_ff;
   logic [48:0] sp4_ff;
   logic [63:0] p1_in;
   logic signed [17:0] sine_s;
   logic [48:0] sp4_in;
   always_comb begin
      p1_in  = $signed(acc2_ff) * $signed(x3_ff);
      sine_s = neg3_ff ? -$signed({1'b0, rom3_ff}) : $signed({1'b0, rom3_ff});
      sp4_in = $signed(amp_ff) * sine_s;
   end

   // Stage 5: add for step one, bias plus floor of scaled sine.
   logic [31:0] x5_ff, acc1_ff, ys5_ff;
   logic        clip5_ff, sclip5_ff;
   logic [32:0] step1_in, sine_in;
   logic signed [48:0] sine_sum;
   always_comb begin
      step1_in = horner_step(p1_ff, c1, count_ff > 3'd1);
      sine_sum = $signed({{16{sp4_ff[48]}}, sp4_ff[48:16]})
               + $signed({{17{bias_ff[31]}}, bias_ff});
      sine_in  = sat32(sine_sum);
   end

   // Stage 6: multiply for step zero.
   logic [63:0] p0_ff, p0_in;
   logic [31:0] ys6_ff;
   logic        clip6_ff, sclip6_ff;
   assign p0_in = $signed(acc1_ff) * $signed(x5_ff);

   // Stage 7: add for step zero, select by mode into the output word.
   logic [31:0] y_ff, y_in;
   logic        sat_ff, sat_in;
   logic [32:0] step0_in;
   always_comb begin
      step0_in = horner_step(p0_ff, c0, count_ff > 3'd0);
      case (mode_ff)
         cfg_pkg::MODE_CONST: begin
            y_in   = (count_ff > 3'd0) ? c0 : 32'd0;
            sat_in = 1'b0;
         end
         cfg_pkg::MODE_POLY: begin
            y_in   = step0_in[31:0];
            sat_in = clip6_ff | step0_in[32];
         end
         cfg_pkg::MODE_SINE: begin
            y_in   = ys6_ff;
            sat_in = sclip6_ff;
         end
         default: begin
            y_in   = 32'd0;
            sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         x1_ff     <= req_tdata;
         acc3_ff   <= acc3_in;
         fx1_ff    <= fx1_in;

         x2_ff     <= x1_ff;
         p2_ff     <= p2_in;
         angle2_ff <= angle2_in;

         x3_ff     <= x2_ff;
         acc2_ff   <= step2_in[31:0];
         clip3_ff  <= step2_in[32];
         rom3_ff   <= cfg_pkg::SINE_ROM[sine_addr];
         neg3_ff   <= angle2_ff[31];

         x4_ff     <= x3_ff;
         p1_ff     <= p1_in;
         sp4_ff    <= sp4_in;
         clip4_ff  <= clip3_ff;

         x5_ff     <= x4_ff;
         acc1_ff   <= step1_in[31:0];
         clip5_ff  <= clip4_ff | step1_in[32];
         ys5_ff    <= sine_in[31:0];
         sclip5_ff <= sine_in[32];

         p0_ff     <= p0_in;
         clip6_ff  <= clip5_ff;
         ys6_ff    <= ys5_ff;
         sclip6_ff <= sclip5_ff;

         y_ff      <= y_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_tdata = y_ff;
   assign rsp_tuser = sat_ff;

endmodule
